// ===== rtl/dq_pkg.sv =====
// ---------------------------------------------------------------------------
// dq_pkg
// Shared types, codes and ring-index helpers for the double-ended queue.
// ---------------------------------------------------------------------------
package dq_pkg;

    localparam int DEPTH = 16;                    // queue capacity, 2..64
    localparam int IDX_W = $clog2(DEPTH);         // ring index width
    localparam int CNT_W = $clog2(DEPTH + 1);     // element count width

    localparam logic [IDX_W:0] DEPTH_IDX = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] DEPTH_M1 = IDX_W'(DEPTH - 1);

    // operation codes
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_DUMP       = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } mem_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_DUMP
    } state_t;

    // (a + b) mod DEPTH, both operands below DEPTH
    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [IDX_W-1:0] b);
        logic [IDX_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_IDX)
            sum = sum - DEPTH_IDX;
        return sum[IDX_W-1:0];
    endfunction

endpackage

// ===== rtl/dq_ram.sv =====
// ---------------------------------------------------------------------------
// dq_ram
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module dq_ram
    import dq_pkg::*;
(
    input  logic               clk,
    input  mem_cmd_t           cmd,
    input  logic signed [31:0] wr_data,
    output logic signed [31:0] rd_data
);

    logic signed [31:0] mem [DEPTH];
    logic signed [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
            mem[cmd.wr_addr] <= wr_data;
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
            rd_data_reg <= mem[cmd.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring memory.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation per
//   transaction: push front, push back, pop front, pop back or dump.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns the results from a
//   registered output stage; every operation ends with a result with last set.
// Timing:
//   push, rejected ops and unknown codes: result loaded into the output register on accept.
//   pop: through the synchronous memory read register, then the output register.
//   dump of N elements: N results, each through the memory read register
//   and output register, one per cycle unless stalled (single read port).
//   One operation is in flight at a time; the next request is taken once
//   the final result of the previous one sits in the output register and
//   that register is empty or being drained, so unstalled back-to-back
//   pushes run at one per cycle, while a pop holds off the next request until its read data is loaded.
// Reset: queue empty, front index zero; memory contents are not cleared,
//   only held positions are ever read.
// Stall: a stalled result holds in the output register; the dump stream
//   pauses with the pending element parked in the memory read register.
// ---------------------------------------------------------------------------
module double_ended_queue
    import dq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   dump_idx_reg, dump_idx_next;
    logic               rsp_valid_reg, rsp_valid_next;
    rsp_t               rsp_reg, rsp_next;

    mem_cmd_t           mem_cmd;
    logic signed [31:0] rd_data;

    logic               slot_free;
    logic               accept;
    logic               load;
    logic               is_full;
    logic               is_empty;
    logic [CNT_W-1:0]   count_m1;
    logic [IDX_W-1:0]   count_idx;
    logic [IDX_W-1:0]   count_m1_idx;
    logic               dump_last;

    dq_ram u_ram (
        .clk     (clk),
        .cmd     (mem_cmd),
        .wr_data (req.value),
        .rd_data (rd_data)
    );

    // output slot is free when empty or being taken this edge
    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && slot_free);
    assign accept    = req_valid && !req_stall;

    assign is_full      = (count_reg == DEPTH_CNT);
    assign is_empty     = (count_reg == '0);
    // count_idx only used when not full, count_m1_idx only when not empty
    assign count_m1     = count_reg - 1'b1;
    assign count_idx    = count_reg[IDX_W-1:0];
    assign count_m1_idx = count_m1[IDX_W-1:0];
    assign dump_last    = ((CNT_W'(dump_idx_reg) + 1'b1) == count_reg);

    always_comb
    begin
        state_next    = state_reg;
        front_next    = front_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        load          = 1'b0;
        rsp_next      = rsp_reg;
        mem_cmd       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    load        = 1'b1;
                    rsp_next    = '{data: '0, status: ST_OK, last: 1'b1};
                    unique case (req.op)
                        OP_PUSH_FRONT:
                        begin
                            if (is_full)
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                front_next      = ring_add(front_reg, DEPTH_M1);
                                count_next      = count_reg + 1'b1;
                                mem_cmd.wr_en   = 1'b1;
                                mem_cmd.wr_addr = ring_add(front_reg, DEPTH_M1);
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (is_full)
                                rsp_next.status = ST_FULL;
                            else
                            begin
                                count_next      = count_reg + 1'b1;
                                mem_cmd.wr_en   = 1'b1;
                                mem_cmd.wr_addr = ring_add(front_reg, count_idx);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (is_empty)
                                rsp_next.status = ST_EMPTY;
                            else
                            begin
                                // result comes from the memory next cycle
                                load            = 1'b0;
                                state_next      = S_POP;
                                mem_cmd.rd_en   = 1'b1;
                                count_next      = count_m1;
                                if (req.op == OP_POP_FRONT)
                                begin
                                    mem_cmd.rd_addr = front_reg;
                                    front_next      = ring_add(front_reg, IDX_W'(1));
                                end
                                else
                                    mem_cmd.rd_addr = ring_add(front_reg, count_m1_idx);
                                // popping the only element empties both ends
                                if (count_reg == CNT_W'(1))
                                    front_next = '0;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (is_empty)
                                rsp_next.status = ST_EMPTY;
                            else
                            begin
                                load            = 1'b0;
                                state_next      = S_DUMP;
                                dump_idx_next   = '0;
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = front_reg;
                            end
                        end
                        default:
                        begin
                            // unknown code: plain ok result
                        end
                    endcase
                end
            end
            S_POP:
            begin
                if (slot_free)
                begin
                    load       = 1'b1;
                    rsp_next   = '{data: rd_data, status: ST_OK, last: 1'b1};
                    state_next = S_IDLE;
                end
            end
            S_DUMP:
            begin
                if (slot_free)
                begin
                    load     = 1'b1;
                    rsp_next = '{data: rd_data, status: ST_OK, last: dump_last};
                    if (dump_last)
                        state_next = S_IDLE;
                    else
                    begin
                        dump_idx_next   = dump_idx_reg + 1'b1;
                        mem_cmd.rd_en   = 1'b1;
                        mem_cmd.rd_addr = ring_add(front_reg, dump_idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (load)
            rsp_valid_next = 1'b1;
        else if (rsp_valid_reg && !rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            dump_idx_reg  <= dump_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("element count above capacity");

    a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (front_reg == '0))
        else $error("empty queue with nonzero front index");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.last && (rsp.data == '0)))
        else $error("error result must be a single zero result");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> ((state_reg != S_IDLE) || rsp_valid))
        else $error("accepted transaction produced no work");

endmodule
